// ===== rtl/gle_pkg.sv =====
// Shared types, constants and the control store for the GCD/LCM block.
// Used by gle_datapath, gcd_lcm_euclid and the testbench; depends on nothing else.
package gle_pkg;

	// Fixed field widths of the request and result ports.
	localparam int OPERAND_WIDTH  = 32;
	localparam int GCD_WIDTH      = 32;
	localparam int LCM_WIDTH      = 63;
	localparam int DATA_WIDTH_DEF = 32;

	// Step address of the control store.
	typedef logic [3:0] step_t;

	localparam step_t STEP_IDLE   = 4'd0;
	localparam step_t STEP_ZCHK   = 4'd1;
	localparam step_t STEP_COMMON = 4'd2;
	localparam step_t STEP_STRIPX = 4'd3;
	localparam step_t STEP_REDUCE = 4'd4;
	localparam step_t STEP_FORM   = 4'd5;
	localparam step_t STEP_DIV    = 4'd6;
	localparam step_t STEP_MUL    = 4'd7;
	localparam step_t STEP_ZERO   = 4'd8;
	localparam step_t STEP_EMIT   = 4'd9;
	localparam step_t STEP_RETRY  = 4'd10;

	// Datapath operations.
	typedef enum logic [3:0] {
		OP_NOP,
		OP_LOAD,
		OP_STRIP_COMMON,
		OP_STRIP_X,
		OP_REDUCE,
		OP_FORM,
		OP_DIV,
		OP_MUL,
		OP_ZERO,
		OP_EMIT
	} op_t;

	// Jump conditions; a step jumps to its target when its condition holds.
	typedef enum logic [3:0] {
		C_NEXT,
		C_ALWAYS,
		C_NO_REQ,
		C_ANY_ZERO,
		C_BOTH_EVEN,
		C_X_EVEN,
		C_Y_NONZERO,
		C_CNT_MORE,
		C_OUT_FREE
	} cond_t;

	// One control word of the program.
	typedef struct packed {
		op_t   op;
		cond_t cond;
		step_t target;
	} ctrl_word_t;

	// Flags that the datapath reports to the sequencer.
	typedef struct packed {
		logic any_zero;
		logic both_even;
		logic x_even;
		logic y_nonzero;
		logic cnt_more;
	} dp_status_t;

	// Control store: zero check, binary GCD reduction, exact division of |a| by the
	// divisor, then one multiply by |b|; a zero operand skips to the zero result.
	function automatic ctrl_word_t ucode_rom(input step_t pc);
		ctrl_word_t w;
		unique case (pc)
			STEP_IDLE:   w = '{op: OP_LOAD,         cond: C_NO_REQ,    target: STEP_IDLE};
			STEP_ZCHK:   w = '{op: OP_NOP,          cond: C_ANY_ZERO,  target: STEP_ZERO};
			STEP_COMMON: w = '{op: OP_STRIP_COMMON, cond: C_BOTH_EVEN, target: STEP_COMMON};
			STEP_STRIPX: w = '{op: OP_STRIP_X,      cond: C_X_EVEN,    target: STEP_STRIPX};
			STEP_REDUCE: w = '{op: OP_REDUCE,       cond: C_Y_NONZERO, target: STEP_REDUCE};
			STEP_FORM:   w = '{op: OP_FORM,         cond: C_NEXT,      target: STEP_IDLE};
			STEP_DIV:    w = '{op: OP_DIV,          cond: C_CNT_MORE,  target: STEP_DIV};
			STEP_MUL:    w = '{op: OP_MUL,          cond: C_ALWAYS,    target: STEP_EMIT};
			STEP_ZERO:   w = '{op: OP_ZERO,         cond: C_NEXT,      target: STEP_IDLE};
			STEP_EMIT:   w = '{op: OP_EMIT,         cond: C_OUT_FREE,  target: STEP_IDLE};
			STEP_RETRY:  w = '{op: OP_NOP,          cond: C_ALWAYS,    target: STEP_EMIT};
			default:     w = '{op: OP_NOP,          cond: C_ALWAYS,    target: STEP_IDLE};
		endcase
		return w;
	endfunction

endpackage

// ===== rtl/gle_datapath.sv =====
// Datapath of the GCD/LCM block: magnitude registers, reduction, divider
// and multiplier, each driven by one operation code. Depends on gle_pkg.
module gle_datapath #(
	parameter int DATA_WIDTH = gle_pkg::DATA_WIDTH_DEF
) (
	input  logic                                clk,
	input  gle_pkg::op_t                        op,
	input  logic signed [gle_pkg::OPERAND_WIDTH-1:0] operand_a,
	input  logic signed [gle_pkg::OPERAND_WIDTH-1:0] operand_b,
	output gle_pkg::dp_status_t                 status,
	output logic [DATA_WIDTH-1:0]               gcd_res,
	output logic [2*DATA_WIDTH-1:0]             lcm_res
);
	import gle_pkg::*;

	localparam int W  = DATA_WIDTH;
	localparam int KW = $clog2(W);
	localparam int CW = $clog2(W + 1);

	logic [W-1:0]   raw_a, raw_b, mag_a, mag_b;
	logic [W-1:0]   ma_q, mb_q, x_q, y_q, gcd_q, rem_q, quo_q;
	logic [KW-1:0]  k_q;
	logic [CW-1:0]  cnt_q;
	logic [2*W-1:0] lcm_q, prod;
	logic [W:0]     div_shift, div_diff;
	logic           div_ge;

	// Magnitudes of the low DATA_WIDTH bits of each operand.
	always_comb begin
		raw_a = operand_a[W-1:0];
		raw_b = operand_b[W-1:0];
		mag_a = raw_a[W-1] ? (~raw_a) + W'(1) : raw_a;
		mag_b = raw_b[W-1] ? (~raw_b) + W'(1) : raw_b;
	end

	// One restoring division step and the final product.
	always_comb begin
		div_shift = {rem_q, quo_q[W-1]};
		div_diff  = div_shift - {1'b0, gcd_q};
		div_ge    = !div_diff[W];
		prod      = {{W{1'b0}}, quo_q} * {{W{1'b0}}, mb_q};
	end

	// Register updates selected by the current operation.
	always_ff @(posedge clk) begin
		unique case (op)
			OP_LOAD: begin
				ma_q <= mag_a;
				mb_q <= mag_b;
				x_q  <= mag_a;
				y_q  <= mag_b;
				k_q  <= '0;
			end
			OP_STRIP_COMMON: begin
				if (!x_q[0] && !y_q[0]) begin
					x_q <= x_q >> 1;
					y_q <= y_q >> 1;
					k_q <= k_q + KW'(1);
				end
			end
			OP_STRIP_X: begin
				if (!x_q[0]) begin
					x_q <= x_q >> 1;
				end
			end
			OP_REDUCE: begin
				// x is odd here; halve an even y, else subtract the smaller.
				if (y_q != '0) begin
					if (!y_q[0]) begin
						y_q <= y_q >> 1;
					end else if (x_q > y_q) begin
						x_q <= y_q;
						y_q <= x_q - y_q;
					end else begin
						y_q <= y_q - x_q;
					end
				end
			end
			OP_FORM: begin
				gcd_q <= x_q << k_q;
				rem_q <= '0;
				quo_q <= ma_q;
				cnt_q <= CW'(W);
			end
			OP_DIV: begin
				rem_q <= div_ge ? div_diff[W-1:0] : div_shift[W-1:0];
				quo_q <= {quo_q[W-2:0], div_ge};
				cnt_q <= cnt_q - CW'(1);
			end
			OP_MUL: begin
				lcm_q <= prod;
			end
			OP_ZERO: begin
				// One magnitude is zero, so the divisor is the other one.
				gcd_q <= x_q | y_q;
				lcm_q <= '0;
			end
			OP_NOP, OP_EMIT: begin
			end
			default: begin
			end
		endcase
	end

	// Flags for the sequencer's jump conditions.
	always_comb begin
		status.any_zero  = (x_q == '0) || (y_q == '0);
		status.both_even = !x_q[0] && !y_q[0];
		status.x_even    = !x_q[0];
		status.y_nonzero = (y_q != '0);
		status.cnt_more  = (cnt_q != CW'(1));
	end

	assign gcd_res = gcd_q;
	assign lcm_res = lcm_q;

endmodule

// ===== rtl/gcd_lcm_euclid.sv =====
// Top level of the GCD/LCM block: microcode sequencer and result register.
// Depends on gle_pkg and gle_datapath.
//
//  channel | signals                          | direction | width
//  --------+----------------------------------+-----------+--------------
//  request | in_valid, in_stall, operand_a/b  | in        | 32 + 32 signed
//  result  | out_valid, out_stall, gcd_value, | out       | 32 + 63
//          | lcm_value                        |           |
//
// After its accept, a request with a zero operand runs the zero check, the zero step
// and emit. Otherwise it runs the zero check, the common and x halving loops, the
// reduction loop, the form step, the bit-serial divider, the multiply and emit; emit
// repeats through the retry step while out_stall holds back a waiting result.
// Reset clears the step counter and the result valid flag; nothing else.
// A request is taken while a result waits under out_stall; the next one waits in emit.
module gcd_lcm_euclid #(
	parameter int DATA_WIDTH = gle_pkg::DATA_WIDTH_DEF
) (
	input  logic                                     clk,
	input  logic                                     arst_n,
	input  logic                                     in_valid,
	output logic                                     in_stall,
	input  logic signed [gle_pkg::OPERAND_WIDTH-1:0] operand_a,
	input  logic signed [gle_pkg::OPERAND_WIDTH-1:0] operand_b,
	output logic                                     out_valid,
	input  logic                                     out_stall,
	output logic        [gle_pkg::GCD_WIDTH-1:0]     gcd_value,
	output logic        [gle_pkg::LCM_WIDTH-1:0]     lcm_value
);
	import gle_pkg::*;

	step_t                   pc_q, pc_next;
	ctrl_word_t              ctrl;
	op_t                     dp_op;
	dp_status_t              status;
	logic                    jump, out_free, emit;
	logic                    out_valid_q;
	logic [GCD_WIDTH-1:0]    gcd_out_q;
	logic [LCM_WIDTH-1:0]    lcm_out_q;
	logic [DATA_WIDTH-1:0]   gcd_res;
	logic [2*DATA_WIDTH-1:0] lcm_res;

	gle_datapath #(
		.DATA_WIDTH(DATA_WIDTH)
	) u_datapath (
		.clk      (clk),
		.op       (dp_op),
		.operand_a(operand_a),
		.operand_b(operand_b),
		.status   (status),
		.gcd_res  (gcd_res),
		.lcm_res  (lcm_res)
	);

	// Current control word.
	assign ctrl = ucode_rom(pc_q);

	// Jump condition and next step address.
	always_comb begin
		unique case (ctrl.cond)
			C_NEXT:      jump = 1'b0;
			C_ALWAYS:    jump = 1'b1;
			C_NO_REQ:    jump = !in_valid;
			C_ANY_ZERO:  jump = status.any_zero;
			C_BOTH_EVEN: jump = status.both_even;
			C_X_EVEN:    jump = status.x_even;
			C_Y_NONZERO: jump = status.y_nonzero;
			C_CNT_MORE:  jump = status.cnt_more;
			C_OUT_FREE:  jump = out_free;
			default:     jump = 1'b1;
		endcase
		pc_next = jump ? ctrl.target : pc_q + step_t'(1);
	end

	// Handshake and datapath controls of the current step.
	always_comb begin
		out_free = !out_valid_q || !out_stall;
		in_stall = (pc_q != STEP_IDLE);
		emit     = (ctrl.op == OP_EMIT) && out_free;
		dp_op    = (ctrl.op == OP_LOAD && !in_valid) ? OP_NOP : ctrl.op;
	end

	// Step counter.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			pc_q <= STEP_IDLE;
		end else begin
			pc_q <= pc_next;
		end
	end

	// Result register; it holds while the consumer stalls.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (emit) begin
			out_valid_q <= 1'b1;
		end else if (!out_stall) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (emit) begin
			gcd_out_q <= GCD_WIDTH'(gcd_res);
			lcm_out_q <= LCM_WIDTH'(lcm_res);
		end
	end

	assign out_valid = out_valid_q;
	assign gcd_value = gcd_out_q;
	assign lcm_value = lcm_out_q;

	// An accepted request always starts at the zero check.
	a_accept_start: assert property (@(posedge clk) disable iff (!arst_n)
		(in_valid && !in_stall) |=> (pc_q == STEP_ZCHK))
		else $error("accepted request did not start at the zero check");

	// The result register is only loaded by the emit step.
	a_emit_only: assert property (@(posedge clk) disable iff (!arst_n)
		$rose(out_valid_q) |-> ($past(pc_q) == STEP_EMIT))
		else $error("result appeared outside the emit step");

	// A nonzero multiple always comes with a nonzero divisor.
	a_lcm_gcd: assert property (@(posedge clk) disable iff (!arst_n)
		(out_valid_q && lcm_value != '0) |-> (gcd_value != '0))
		else $error("nonzero lcm with zero gcd");

	// The step counter stays inside the program.
	a_pc_range: assert property (@(posedge clk) disable iff (!arst_n)
		(pc_q <= STEP_RETRY))
		else $error("step counter left the program");

	// No request is taken while the divider is running.
	a_div_busy: assert property (@(posedge clk) disable iff (!arst_n)
		(pc_q == STEP_DIV) |-> in_stall)
		else $error("request port open during division");

endmodule

// ===== dv/gcd_lcm_euclid_tb.sv =====
// Self-checking testbench for gcd_lcm_euclid: random and directed operand pairs,
// with results checked against a built-in gcd/lcm calculation.
// Depends on gle_pkg and the gcd_lcm_euclid RTL only.
`timescale 1ns / 1ps

module gcd_lcm_euclid_tb;
	import gle_pkg::*;

	localparam int RANDOM_REQUESTS = 680;
	localparam int SETTLE_CYCLES   = 5 * DATA_WIDTH_DEF + 40;
	localparam int HOLD_CYCLES     = 800;

	// One request as driven on the operand ports.
	typedef struct packed {
		logic [OPERAND_WIDTH-1:0] a;
		logic [OPERAND_WIDTH-1:0] b;
	} operand_pair_t;

	// One result as it should appear on the output ports.
	typedef struct packed {
		logic [GCD_WIDTH-1:0] gcd;
		logic [LCM_WIDTH-1:0] lcm;
	} divisor_multiple_t;

	logic                            clk       = 1'b0;
	logic                            arst_n    = 1'b0;
	logic                            in_valid  = 1'b0;
	logic                            in_stall;
	logic signed [OPERAND_WIDTH-1:0] operand_a = '0;
	logic signed [OPERAND_WIDTH-1:0] operand_b = '0;
	logic                            out_valid;
	logic                            out_stall = 1'b0;
	logic        [GCD_WIDTH-1:0]     gcd_value;
	logic        [LCM_WIDTH-1:0]     lcm_value;

	operand_pair_t     pending_pairs[$];
	divisor_multiple_t expected_results[$];
	operand_pair_t     next_pair;
	operand_pair_t     send_pair;
	divisor_multiple_t oldest_result;

	int unsigned total_requests = 0;
	int unsigned n_sent         = 0;
	int unsigned n_checked      = 0;
	int unsigned n_zero_operand = 0;
	int unsigned n_held_cycles  = 0;
	int unsigned n_fail         = 0;
	int unsigned send_gap       = 0;
	int unsigned stall_left     = 0;
	int unsigned stall_pick     = 0;
	int unsigned hold_left      = 0;
	logic        hold_done      = 1'b0;

	gcd_lcm_euclid dut (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (in_valid),
		.in_stall  (in_stall),
		.operand_a (operand_a),
		.operand_b (operand_b),
		.out_valid (out_valid),
		.out_stall (out_stall),
		.gcd_value (gcd_value),
		.lcm_value (lcm_value)
	);

	// Greatest common divisor and least common multiple of the operand magnitudes.
	function automatic divisor_multiple_t gcd_lcm_of(input logic [OPERAND_WIDTH-1:0] a,
			input logic [OPERAND_WIDTH-1:0] b);
		logic [63:0]       mag_a;
		logic [63:0]       mag_b;
		logic [63:0]       x;
		logic [63:0]       y;
		logic [63:0]       rem;
		logic [63:0]       multiple;
		divisor_multiple_t res;
		mag_a = 64'(a);
		mag_b = 64'(b);
		// The most negative value keeps its exact magnitude at 64 bits.
		if (a[OPERAND_WIDTH-1]) mag_a = (64'd1 << OPERAND_WIDTH) - mag_a;
		if (b[OPERAND_WIDTH-1]) mag_b = (64'd1 << OPERAND_WIDTH) - mag_b;
		x = mag_a;
		y = mag_b;
		while (y != 0) begin
			rem = x % y;
			x = y;
			y = rem;
		end
		multiple = 64'd0;
		if (mag_a != 0 && mag_b != 0) multiple = (mag_a / x) * mag_b;
		res.gcd = x[GCD_WIDTH-1:0];
		res.lcm = multiple[LCM_WIDTH-1:0];
		return res;
	endfunction

	// Idle length: mostly none or short, a few long, none at all in calm stretches.
	function automatic int unsigned pick_idle(input logic calm);
		int unsigned r;
		r = $urandom_range(0, 99);
		if (calm || r < 55) return 0;
		if (r < 92) return $urandom_range(1, 3);
		return $urandom_range(10, 40);
	endfunction

	// Random sign for a magnitude.
	function automatic logic [OPERAND_WIDTH-1:0] signed_of(input logic [OPERAND_WIDTH-1:0] mag);
		return $urandom_range(0, 1) ? -mag : mag;
	endfunction

	// Random request, weighted toward pairs with shared factors.
	function automatic operand_pair_t make_random_pair();
		operand_pair_t p;
		logic [OPERAND_WIDTH-1:0] g;
		logic [OPERAND_WIDTH-1:0] special;
		int unsigned kind;
		kind = $urandom_range(0, 9);
		g = $urandom_range(1, 65535);
		case ($urandom_range(0, 4))
			0: special = 32'h8000_0000;
			1: special = 32'h7FFF_FFFF;
			2: special = 32'hFFFF_FFFF;
			3: special = 32'd1;
			default: special = 32'd0;
		endcase
		case (kind)
			0, 1, 2: begin
				p.a = $urandom();
				p.b = $urandom();
			end
			3, 4, 5: begin
				// Shared factor up to 16 bits times cofactors up to 15 bits.
				g = g >> $urandom_range(0, 15);
				if (g == 0) g = 1;
				p.a = signed_of(g * $urandom_range(0, 32767));
				p.b = signed_of(g * $urandom_range(0, 32767));
			end
			6: begin
				p.a = signed_of($urandom_range(0, 50));
				p.b = signed_of($urandom_range(0, 50));
			end
			7: begin
				p.a = special;
				p.b = $urandom() >> $urandom_range(0, 31);
				if ($urandom_range(0, 1)) p = '{a: p.b, b: p.a};
			end
			8: begin
				// Powers of two times small odd numbers exercise the halving steps.
				p.a = signed_of(OPERAND_WIDTH'({11'($urandom_range(0, 2047)), 1'b1})
					<< $urandom_range(0, 19));
				p.b = signed_of(OPERAND_WIDTH'({11'($urandom_range(0, 2047)), 1'b1})
					<< $urandom_range(0, 19));
			end
			default: begin
				p.a = $urandom() >> $urandom_range(0, 31);
				p.b = signed_of(p.a * $urandom_range(1, 3));
				p.a = signed_of(p.a);
			end
		endcase
		return p;
	endfunction

	task automatic queue_pair(input logic [OPERAND_WIDTH-1:0] a,
			input logic [OPERAND_WIDTH-1:0] b);
		pending_pairs.push_back('{a: a, b: b});
		total_requests++;
	endtask

	// Clock and reset.
	initial begin
		forever #6 clk = ~clk;
	end

	initial begin
		repeat (8) @(posedge clk);
		arst_n <= 1'b1;
	end

	// Sender: offers queued requests with random gaps and holds a stalled request steady.
	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			in_valid  <= 1'b0;
			operand_a <= '0;
			operand_b <= '0;
			send_gap  <= 0;
		end else begin
			if (in_valid && !in_stall) begin
				expected_results.push_back(gcd_lcm_of(operand_a, operand_b));
				if (operand_a == 0 || operand_b == 0) n_zero_operand++;
				n_sent++;
			end
			if (in_valid && in_stall) begin
				n_held_cycles++;
			end else if (send_gap != 0) begin
				send_gap <= send_gap - 1;
				in_valid <= 1'b0;
			end else if (pending_pairs.size() != 0) begin
				send_pair = pending_pairs.pop_front();
				operand_a <= send_pair.a;
				operand_b <= send_pair.b;
				in_valid  <= 1'b1;
				send_gap  <= pick_idle(((n_sent / 50) % 4) == 3);
			end else begin
				in_valid <= 1'b0;
			end
		end
	end

	// Receiver hold-off: one long stretch of stall partway through the run.
	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			hold_left <= 0;
			hold_done <= 1'b0;
		end else if (hold_left != 0) begin
			hold_left <= hold_left - 1;
		end else if (!hold_done && n_checked >= 150) begin
			hold_left <= HOLD_CYCLES;
			hold_done <= 1'b1;
		end
	end

	// Receiver: checks each accepted result against the oldest expectation.
	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_stall  <= 1'b0;
			stall_left <= 0;
		end else begin
			if (out_valid && !out_stall) begin
				if (expected_results.size() == 0) begin
					$error("result with no request outstanding: gcd_value %0d lcm_value %0d",
						gcd_value, lcm_value);
					n_fail++;
				end else begin
					oldest_result = expected_results.pop_front();
					if (gcd_value !== oldest_result.gcd) begin
						$error("gcd_value mismatch: expected %0d, actual %0d",
							oldest_result.gcd, gcd_value);
						n_fail++;
					end
					if (lcm_value !== oldest_result.lcm) begin
						$error("lcm_value mismatch: expected %0d, actual %0d",
							oldest_result.lcm, lcm_value);
						n_fail++;
					end
				end
				n_checked++;
			end
			if (hold_left != 0) begin
				out_stall <= 1'b1;
			end else if (stall_left != 0) begin
				stall_left <= stall_left - 1;
				out_stall  <= 1'b1;
			end else begin
				stall_pick = pick_idle(((n_checked / 50) % 4) == 1);
				out_stall  <= (stall_pick != 0);
				stall_left <= (stall_pick != 0) ? stall_pick - 1 : 0;
			end
		end
	end

	// Stimulus list and end of run.
	initial begin
		// Zero operands, extremes, the most negative value, then sign mixes and other directed pairs.
		queue_pair(32'd0, 32'd0);
		queue_pair(32'd0, 32'd5);
		queue_pair(-32'd7, 32'd0);
		queue_pair(32'h8000_0000, 32'd0);
		queue_pair(32'd0, 32'h8000_0000);
		queue_pair(32'h8000_0000, 32'h8000_0000);
		queue_pair(32'h8000_0000, 32'h7FFF_FFFF);
		queue_pair(32'h7FFF_FFFF, 32'h8000_0000);
		queue_pair(32'h7FFF_FFFF, 32'h7FFF_FFFE);
		queue_pair(32'h7FFF_FFFF, 32'h7FFF_FFFF);
		queue_pair(32'h8000_0000, 32'd3);
		queue_pair(32'hFFFF_FFFF, 32'hFFFF_FFFF);
		queue_pair(32'd1, 32'hFFFF_FFFF);
		queue_pair(32'd12, 32'd18);
		queue_pair(-32'd12, 32'd18);
		queue_pair(-32'd12, -32'd18);
		queue_pair(32'd1, 32'd1);
		queue_pair(32'h4000_0000, 32'h7FFF_FFFF);
		queue_pair(32'd65536, 32'd65536);
		queue_pair(32'd2147483629, 32'd2147483587);
		queue_pair(32'h8000_0000, 32'h8000_0001);
		queue_pair(32'd46368, 32'd28657);
		queue_pair(32'h5555_5555, 32'hAAAA_AAAA);
		for (int i = 0; i < RANDOM_REQUESTS; i++) begin
			next_pair = make_random_pair();
			queue_pair(next_pair.a, next_pair.b);
		end

		while (n_sent < total_requests || expected_results.size() != 0) @(posedge clk);
		repeat (SETTLE_CYCLES) @(posedge clk);

		$display("Checked %0d results from %0d requests, %0d of them with a zero operand.",
			n_checked, n_sent, n_zero_operand);
		$display("The request side was held back for %0d cycles in total.", n_held_cycles);
		if (n_fail == 0) begin
			$display("gcd_lcm_euclid verification clean");
		end else begin
			$display("gcd_lcm_euclid verification failed");
		end
		$finish;
	end

	// Watchdog for a hung handshake.
	initial begin
		#10_000_000;
		$display("gcd_lcm_euclid verification failed");
		$finish;
	end

endmodule

// ===== filelist.f =====
rtl/gle_pkg.sv
rtl/gle_datapath.sv
rtl/gcd_lcm_euclid.sv
dv/gcd_lcm_euclid_tb.sv
